// ===== rtl/mavg_pkg.sv =====
// Package with sizes, register map and controller/datapath interface types of the boxcar filter.
`timescale 1ns / 1ps

package mavg_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int PTR_BITS    = $clog2(WINDOW_MAX);
  localparam int LEN_BITS    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_BITS    = SAMPLE_BITS + PTR_BITS;
  localparam int CNT_BITS    = $clog2(SUM_BITS);

  localparam int PADDR_BITS  = 3;
  localparam int PDATA_BITS  = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_WINDOW_LEN = 1'b0;

  localparam logic [LEN_BITS-1:0] WINDOW_RESET = LEN_BITS'(4);

  typedef struct packed {
    logic take;      // latch item, write ring, read leaving sample
    logic update;    // update running sum
    logic div_load;  // load divider with |sum|
    logic div_step;  // one quotient bit
    logic out_load;  // move signed quotient into output register
  } mavg_cmd_t;

  typedef struct packed {
    logic has_result;
    logic div_last;
    logic out_free;
  } mavg_status_t;

endpackage

// ===== rtl/mavg_ctrl.sv =====
// Controller state machine: sequences take, sum update and the bit-serial divide.
`timescale 1ns / 1ps

module mavg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  mavg_pkg::mavg_status_t status_i,
  output mavg_pkg::mavg_cmd_t    cmd_o
);
  import mavg_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = status_i.has_result ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/mavg_datapath.sv =====
// Datapath: sample ring, running sum, window register, serial divider and output register.
`timescale 1ns / 1ps

module mavg_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mavg_pkg::mavg_cmd_t                  cmd_i,
  output mavg_pkg::mavg_status_t               status_o,
  input  logic signed [mavg_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                restart_i,
  input  logic                                cfg_wr_i,
  input  logic [mavg_pkg::LEN_BITS-1:0]        cfg_wdata_i,
  output logic [mavg_pkg::LEN_BITS-1:0]        window_len_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [mavg_pkg::SAMPLE_BITS-1:0] out_data_o
);
  import mavg_pkg::*;

  logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];

  logic [LEN_BITS-1:0]           win_q;
  logic [PTR_BITS-1:0]           wp_q;
  logic [LEN_BITS-1:0]           fill_q;
  logic signed [SUM_BITS-1:0]    sum_q;
  logic                          has_res_q, drop_q, restart_q;
  logic signed [SAMPLE_BITS-1:0] rd_q, sample_q;

  logic [SUM_BITS-1:0]           quot_q;
  logic [LEN_BITS-1:0]           rem_q;
  logic [CNT_BITS-1:0]           cnt_q;
  logic                          neg_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_data_q;

  logic [LEN_BITS-1:0]           len;
  logic [PTR_BITS-1:0]           old_idx;
  logic [LEN_BITS-1:0]           fill_eff, fill_nx;
  logic signed [SUM_BITS-1:0]    sum_base, sum_drop, sum_add, sum_nx;
  logic [SUM_BITS-1:0]           sum_mag;
  logic [LEN_BITS-1:0]           trial, trial_sub;
  logic                          trial_ge;
  logic [SAMPLE_BITS-1:0]        quot_s;

  // Window 0 acts as 1, above the ring depth as the depth
  always_comb begin
    if (win_q == '0) begin
      len = LEN_BITS'(1);
    end else if (win_q > LEN_BITS'(WINDOW_MAX)) begin
      len = LEN_BITS'(WINDOW_MAX);
    end else begin
      len = win_q;
    end
  end

  // Full window wraps to the slot being written: read-first memory returns the old sample
  assign old_idx  = wp_q - len[PTR_BITS-1:0];
  assign fill_eff = restart_i ? '0 : fill_q;
  assign fill_nx  = (fill_eff < len) ? fill_eff + LEN_BITS'(1) : fill_eff;

  assign sum_base = restart_q ? '0 : sum_q;
  assign sum_drop = drop_q ? {{PTR_BITS{rd_q[SAMPLE_BITS-1]}}, rd_q} : '0;
  assign sum_add  = {{PTR_BITS{sample_q[SAMPLE_BITS-1]}}, sample_q};
  assign sum_nx   = sum_base - sum_drop + sum_add;

  assign sum_mag  = sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q);

  // Restoring divide step; remainder stays below len, so its top bit is free
  assign trial     = {rem_q[LEN_BITS-2:0], quot_q[SUM_BITS-1]};
  assign trial_ge  = (trial >= len);
  assign trial_sub = trial - len;

  assign quot_s = neg_q ? SAMPLE_BITS'(-quot_q[SAMPLE_BITS-1:0])
                        : quot_q[SAMPLE_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      ring[wp_q] <= sample_i;
      rd_q       <= ring[old_idx];
      sample_q   <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      quot_q <= sum_mag;
      rem_q  <= '0;
      neg_q  <= sum_q[SUM_BITS-1];
    end else if (cmd_i.div_step) begin
      quot_q <= {quot_q[SUM_BITS-2:0], trial_ge};
      rem_q  <= trial_ge ? trial_sub : trial;
    end
    if (cmd_i.out_load) out_data_q <= quot_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WINDOW_RESET;
      wp_q        <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      has_res_q   <= 1'b0;
      drop_q      <= 1'b0;
      restart_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_i) begin
        win_q  <= cfg_wdata_i;
        fill_q <= '0;
        sum_q  <= '0;
      end else begin
        if (cmd_i.take) begin
          wp_q      <= wp_q + PTR_BITS'(1);
          fill_q    <= fill_nx;
          drop_q    <= (fill_eff >= len);
          has_res_q <= (fill_nx >= len);
          restart_q <= restart_i;
        end
        if (cmd_i.update) sum_q <= sum_nx;
      end
      if (cmd_i.div_load) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CNT_BITS'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.has_result = has_res_q;
  assign status_o.div_last   = (cnt_q == CNT_BITS'(SUM_BITS - 1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign window_len_o = win_q;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;

endmodule

// ===== rtl/moving_average_filter.sv =====
// Top level of the boxcar moving average filter: stream ports, APB register port.
`timescale 1ns / 1ps

// Boxcar moving average over the last window_len (1..64) signed 16-bit samples, result
// truncated toward zero. One item is worked on at a time. An item that does not complete
// a window is taken, then updates the sum. One that yields an average holds the block
// through these steps, counting the accepting one: take and ring read, sum update, divider
// load, 22 steps of the bit-serial restoring divider, output load. The average shows on
// m_axis after the output load, and the 22-bit divider loop sets the rate. The output load
// waits while an earlier average has not yet been taken.
// s_axis_tuser = restart starts a new sequence with that sample. Writing window_len at
// address 0 clears the fill count and the sum; write it only while the block is idle.
// The result register lets the next item be accepted while an average waits to be taken.
module moving_average_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        s_axis_tuser,   // [0] restart
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] average
  // APB
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mavg_pkg::*;

  mavg_cmd_t           cmd;
  mavg_status_t        status;
  logic                cfg_wr;
  logic [LEN_BITS-1:0] window_len;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LEN);
  assign prdata = (paddr[2] == REG_WINDOW_LEN) ? PDATA_BITS'(window_len) : '0;

  mavg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mavg_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_i     (s_axis_tdata),
    .restart_i    (s_axis_tuser),
    .cfg_wr_i     (cfg_wr),
    .cfg_wdata_i  (pwdata[LEN_BITS-1:0]),
    .window_len_o (window_len),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (m_axis_tdata)
  );

endmodule

// ===== rtl/mavg_checker.sv =====
// Port-level checker of the boxcar filter and its bind to the top level.
`timescale 1ns / 1ps

module mavg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        pready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  // one item at a time: busy in the cycle after an accept
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while previous item in work");

  // a new result only comes out of the divide, never straight from idle
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a divide");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready && s_axis_tready |=> pready)
    else $error("pready dropped");

endmodule

bind moving_average_filter mavg_checker u_mavg_checker (.*);
